@@ design/tpa_pkg.sv @@
// tpa_pkg: shared types, fixed-point constants and the output rounding function
// for the trig polynomial approximation unit. No dependencies.
`default_nettype none

package tpa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = 30;
    localparam int SHIFT      = COEF_BITS - FRAC_BITS;

    // coefficients, unsigned Q.30
    localparam logic [29:0] K_TWO_OVER_PI = 30'd683565305;
    localparam logic [27:0] K_C0          = 28'd243237849;
    localparam logic [30:0] K_A1          = 31'd1075570192;
    localparam logic [32:0] K_A2          = 33'd4729845942;
    localparam logic [30:0] K_HALF_PI     = 31'd1686629684;
    localparam logic [30:0] K_S1          = 31'd1124145305;
    localparam logic [28:0] K_S3          = 29'd172945448;
    localparam logic [29:0] K_S5          = 30'd570719871;
    localparam logic [30:0] K_T1          = 31'd1069428174;
    localparam logic [28:0] K_T3          = 29'd313834656;
    localparam logic [29:0] K_T5          = 30'd89143764;

    // pipeline layout
    localparam int WAVE_END      = 5;
    localparam int INV_END       = 8;
    localparam int DIV_BITS      = 46;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;
    localparam int PIPE_LAST     = WAVE_END + DIV_STAGES;
    localparam int MAG_W         = 47;

    typedef enum logic [2:0] {
        FN_SIN  = 3'd0,
        FN_COS  = 3'd1,
        FN_TAN  = 3'd2,
        FN_ASIN = 3'd3,
        FN_ACOS = 3'd4,
        FN_ATAN = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_WIDTH-1:0] operand;
    } t_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         overflow;
    } t_rsp;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_wave;

    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [34:0] mag;
    } t_inv;

    typedef struct packed {
        logic neg;
        logic sat;
        logic atan;
        logic acos;
    } t_ictl;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
        logic        tsat;
        logic        tneg;
    } t_side;

    typedef struct packed {
        logic [30:0]         rem;
        logic [15:0]         num;
        logic [30:0]         dvs;
        logic [DIV_BITS-1:0] quo;
    } t_div_st;

    // Q.30 magnitude to output format: round half up, saturate, apply sign
    function automatic t_rsp finish(input logic neg, input logic [MAG_W-1:0] mag,
                                    input logic sat);
        logic [MAG_W:0]  sum;
        logic [33:0]     rnd;
        logic [33:0]     lim;
        logic            ovf;
        logic [31:0]     mg;
        t_rsp            res;
        sum = {1'b0, mag} + ((MAG_W + 1)'(1) << (SHIFT - 1));
        rnd = sum[MAG_W:SHIFT];
        lim = neg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
        ovf = sat || (rnd > lim);
        if (ovf) begin
            rnd = lim;
        end
        mg = rnd[31:0];
        res.value    = neg ? (~mg + 32'd1) : mg;
        res.overflow = ovf;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/tpa_wave.sv @@
// tpa_wave: four-stage quartic evaluation of the sine-shaped wave from a
// Q2.30 quarter-period phase. Depends on tpa_pkg.
`default_nettype none

module tpa_wave (
    input  logic          i_clk,
    input  logic [31:0]   i_phase,
    output tpa_pkg::t_wave o_wave
);

    logic [30:0] n_pa;
    logic [61:0] w_sq;
    logic [30:0] w_a;
    logic [32:0] w_b;
    logic [58:0] w_t;
    logic [61:0] w_m;

    logic [30:0] r_pa;
    logic        r_neg1;
    logic [30:0] r_p2;
    logic        r_neg2;
    logic [28:0] r_t;
    logic [32:0] r_b;
    logic        r_neg3;
    tpa_pkg::t_wave r_out;

    // fold phase fraction to |r - 1|
    always_comb begin
        if (i_phase[30]) begin
            n_pa = {1'b0, i_phase[29:0]};
        end else begin
            n_pa = 31'h4000_0000 - {1'b0, i_phase[29:0]};
        end
    end

    assign w_sq = 62'(r_pa) * 62'(r_pa);
    assign w_a  = tpa_pkg::K_A1 - r_p2;
    assign w_b  = tpa_pkg::K_A2 - 33'(r_p2);
    assign w_t  = 59'(tpa_pkg::K_C0) * 59'(w_a);
    assign w_m  = 62'(r_t) * 62'(r_b);

    always_ff @(posedge i_clk) begin
        r_pa   <= n_pa;
        r_neg1 <= i_phase[31];
        r_p2   <= w_sq[60:30];
        r_neg2 <= r_neg1;
        r_t    <= w_t[58:30];
        r_b    <= w_b;
        r_neg3 <= r_neg2;
        r_out.neg <= r_neg3;
        r_out.mag <= w_m[60:30];
    end

    assign o_wave = r_out;

endmodule

`default_nettype wire

@@ design/tpa_inv.sv @@
// tpa_inv: eight-stage odd quintic for asin, acos and atan, with overflow
// tracking and the acos offset. Depends on tpa_pkg.
`default_nettype none

module tpa_inv (
    input  logic                 i_clk,
    input  logic [2:0]           i_func,
    input  logic signed [31:0]   i_operand,
    output tpa_pkg::t_inv        o_inv
);

    logic [31:0]  w_opu;
    logic [31:0]  w_mag;
    tpa_pkg::t_ictl n_ctl1;
    tpa_pkg::t_ictl n_ctl3;
    tpa_pkg::t_ictl n_ctl7;
    logic [63:0]  w_sq1;
    logic [63:0]  w_sq2;
    logic [28:0]  w_c3;
    logic [29:0]  w_c5;
    logic [30:0]  w_c1;
    logic [62:0]  w_ng;
    logic [63:0]  w_p5;
    logic [34:0]  w_pos;
    logic [34:0]  w_g;
    logic [63:0]  w_pl;
    logic [34:0]  w_ph;
    logic [66:0]  w_full;
    logic signed [35:0] w_sv;
    logic signed [35:0] w_av;
    tpa_pkg::t_inv n_out;

    tpa_pkg::t_ictl r_ctl [1:7];
    logic [31:0]  r_ax [1:5];
    logic [33:0]  r_x2;
    logic [33:0]  r_x4;
    logic [32:0]  r_ng [3:4];
    logic [34:0]  r_pos;
    logic [34:0]  r_g;
    logic [63:0]  r_pl;
    logic [34:0]  r_ph;
    logic [33:0]  r_m;
    tpa_pkg::t_inv r_out;

    assign w_opu = i_operand;
    assign w_mag = w_opu[31] ? (~w_opu + 32'd1) : w_opu;

    always_comb begin
        n_ctl1.neg  = w_opu[31];
        // |x| >= 4 overflows the square of the Q.30 operand
        n_ctl1.sat  = (w_mag[31:18] != '0);
        n_ctl1.atan = (i_func == tpa_pkg::FN_ATAN);
        n_ctl1.acos = (i_func == tpa_pkg::FN_ACOS);
    end

    assign w_sq1 = 64'(r_ax[1]) * 64'(r_ax[1]);
    assign w_sq2 = 64'(r_x2[31:0]) * 64'(r_x2[31:0]);
    assign w_c1  = r_ctl[3].atan ? tpa_pkg::K_T1 : tpa_pkg::K_S1;
    assign w_c3  = r_ctl[2].atan ? tpa_pkg::K_T3 : tpa_pkg::K_S3;
    assign w_c5  = r_ctl[3].atan ? tpa_pkg::K_T5 : tpa_pkg::K_S5;
    assign w_ng  = 63'(w_c3) * 63'(r_x2);
    assign w_p5  = 64'(w_c5) * 64'(r_x4);
    assign w_pos = 35'(w_c1) + 35'(w_p5[63:30]);
    assign w_g   = (r_pos > 35'(r_ng[4])) ? (r_pos - 35'(r_ng[4])) : '0;
    assign w_pl  = 64'(r_ax[5]) * 64'(r_g[31:0]);
    assign w_ph  = 35'(r_ax[5]) * 35'(r_g[34:32]);
    assign w_full = 67'(r_pl) + {r_ph, 32'b0};

    always_comb begin
        n_ctl3 = r_ctl[2];
        // x^2 >= 4.0 overflows x^4
        n_ctl3.sat = r_ctl[2].sat || (r_x2[33:32] != '0);
        n_ctl7 = r_ctl[6];
        n_ctl7.sat = r_ctl[6].sat || (w_full[66:64] != '0);
    end

    assign w_sv = r_ctl[7].neg ? -$signed({2'b0, r_m}) : $signed({2'b0, r_m});
    assign w_av = $signed({5'b0, tpa_pkg::K_HALF_PI}) - w_sv;

    always_comb begin
        n_out.sat = r_ctl[7].sat;
        n_out.neg = r_ctl[7].neg;
        n_out.mag = {1'b0, r_m};
        if (r_ctl[7].sat) begin
            // saturated magnitude exceeds pi/2, so acos takes the opposite sign
            n_out.neg = r_ctl[7].acos ? ~r_ctl[7].neg : r_ctl[7].neg;
        end else if (r_ctl[7].acos) begin
            n_out.neg = w_av[35];
            n_out.mag = w_av[35] ? 35'(-w_av) : 35'(w_av);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[1] <= n_ctl1;
        r_ax[1]  <= {w_mag[17:0], 14'b0};
        r_x2     <= w_sq1[63:30];
        r_ctl[2] <= r_ctl[1];
        r_ax[2]  <= r_ax[1];
        r_x4     <= w_sq2[63:30];
        r_ng[3]  <= w_ng[62:30];
        r_ctl[3] <= n_ctl3;
        r_ax[3]  <= r_ax[2];
        r_pos    <= w_pos;
        r_ng[4]  <= r_ng[3];
        r_ctl[4] <= r_ctl[3];
        r_ax[4]  <= r_ax[3];
        r_g      <= w_g;
        r_ctl[5] <= r_ctl[4];
        r_ax[5]  <= r_ax[4];
        r_pl     <= w_pl;
        r_ph     <= w_ph;
        r_ctl[6] <= r_ctl[5];
        r_m      <= w_full[63:30];
        r_ctl[7] <= n_ctl7;
        r_out    <= n_out;
    end

    assign o_inv = r_out;

endmodule

`default_nettype wire

@@ design/tpa_div.sv @@
// tpa_div: pipelined restoring divider, quotient floor(sin * 2^30 / cos)
// for quotients below 2^46, two bits per stage. Depends on tpa_pkg.
`default_nettype none

module tpa_div (
    input  logic        i_clk,
    input  logic [30:0] i_sin,
    input  logic [30:0] i_cos,
    output logic [tpa_pkg::DIV_BITS-1:0] o_quo
);

    function automatic tpa_pkg::t_div_st div_stage(input tpa_pkg::t_div_st st_in);
        tpa_pkg::t_div_st st;
        logic [31:0]      trial;
        st = st_in;
        for (int j = 0; j < tpa_pkg::DIV_PER_STAGE; j++) begin
            trial  = {st.rem, st.num[15]};
            st.num = {st.num[14:0], 1'b0};
            if (trial >= {1'b0, st.dvs}) begin
                st.rem = 31'(trial - {1'b0, st.dvs});
                st.quo = {st.quo[tpa_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                st.rem = trial[30:0];
                st.quo = {st.quo[tpa_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
        return st;
    endfunction

    tpa_pkg::t_div_st n_init;
    tpa_pkg::t_div_st r_st [0:tpa_pkg::DIV_STAGES-1];

    // partial remainder starts with the bits above quotient weight 2^45
    always_comb begin
        n_init.rem = {16'b0, i_sin[30:16]};
        n_init.num = i_sin[15:0];
        n_init.dvs = i_cos;
        n_init.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= div_stage(n_init);
        for (int k = 1; k < tpa_pkg::DIV_STAGES; k++) begin
            r_st[k] <= div_stage(r_st[k-1]);
        end
    end

    assign o_quo = r_st[tpa_pkg::DIV_STAGES-1].quo;

endmodule

`default_nettype wire

@@ design/trig_poly_approx_unit.sv @@
// trig_poly_approx_unit: top level; phase scaling, sine/cosine wave units,
// tangent divider, inverse polynomial and output rounding. Depends on tpa_pkg.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------
//   request  | start / busy     | i_req  (func, operand)
//   result   | o_strobe         | o_rsp  (value, overflow)
//
// One request per cycle outside reset; results come out in order, the depth
// set by the 23-stage tangent divider after the 5-stage wave path.
// busy is high only while reset is asserted; reset clears the valid bits.
// Results are shown for one cycle and cannot be held off.
`default_nettype none

module trig_poly_approx_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tpa_pkg::t_req i_req,
    output logic          o_strobe,
    output tpa_pkg::t_rsp o_rsp
);

    localparam int LAST = tpa_pkg::PIPE_LAST;

    logic                 w_acc;
    logic signed [62:0]   w_prod;
    logic [31:0]          w_phase;
    tpa_pkg::t_wave       w_sin;
    tpa_pkg::t_wave       w_cos;
    tpa_pkg::t_inv        w_inv;
    logic [tpa_pkg::DIV_BITS-1:0] w_quo;
    tpa_pkg::t_side       n_side;
    tpa_pkg::t_rsp        n_rsp;

    logic                 r_vld  [1:LAST];
    logic [2:0]           r_func [1:LAST];
    logic [31:0]          r_ph_s;
    logic [31:0]          r_ph_c;
    tpa_pkg::t_side       r_side [tpa_pkg::WAVE_END+1:LAST];
    tpa_pkg::t_inv        r_iv   [tpa_pkg::INV_END+1:LAST];
    logic                 r_stb;
    tpa_pkg::t_rsp        r_rsp;

    assign busy  = ~i_rst_n;
    assign w_acc = start && !busy;

    // angle * 2/pi; the kept bits are the quarter-period phase modulo 4
    assign w_prod  = $signed(i_req.operand) * $signed({1'b0, tpa_pkg::K_TWO_OVER_PI});
    assign w_phase = w_prod[tpa_pkg::FRAC_BITS+31:tpa_pkg::FRAC_BITS];

    tpa_wave u_sin (
        .i_clk   (i_clk),
        .i_phase (r_ph_s),
        .o_wave  (w_sin)
    );

    tpa_wave u_cos (
        .i_clk   (i_clk),
        .i_phase (r_ph_c),
        .o_wave  (w_cos)
    );

    tpa_div u_div (
        .i_clk (i_clk),
        .i_sin (w_sin.mag),
        .i_cos (w_cos.mag),
        .o_quo (w_quo)
    );

    tpa_inv u_inv (
        .i_clk     (i_clk),
        .i_func    (i_req.func),
        .i_operand (i_req.operand),
        .o_inv     (w_inv)
    );

    always_comb begin
        if (r_func[tpa_pkg::WAVE_END] == tpa_pkg::FN_COS) begin
            n_side.neg = w_cos.neg;
            n_side.mag = w_cos.mag;
        end else begin
            n_side.neg = w_sin.neg;
            n_side.mag = w_sin.mag;
        end
        // quotient of 2^46 or more, or a zero cosine, saturates
        n_side.tsat = (w_cos.mag == '0) ||
                      ({16'b0, w_sin.mag} >= {w_cos.mag, 16'b0});
        n_side.tneg = (w_cos.mag == '0) ? w_sin.neg : (w_sin.neg ^ w_cos.neg);
    end

    always_comb begin
        unique case (r_func[LAST])
            tpa_pkg::FN_SIN, tpa_pkg::FN_COS: begin
                n_rsp = tpa_pkg::finish(r_side[LAST].neg,
                                        tpa_pkg::MAG_W'(r_side[LAST].mag), 1'b0);
            end
            tpa_pkg::FN_TAN: begin
                n_rsp = tpa_pkg::finish(r_side[LAST].tneg,
                                        tpa_pkg::MAG_W'(w_quo), r_side[LAST].tsat);
            end
            tpa_pkg::FN_ASIN, tpa_pkg::FN_ACOS, tpa_pkg::FN_ATAN: begin
                n_rsp = tpa_pkg::finish(r_iv[LAST].neg,
                                        tpa_pkg::MAG_W'(r_iv[LAST].mag), r_iv[LAST].sat);
            end
            default: begin
                n_rsp.value    = '0;
                n_rsp.overflow = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_stb <= 1'b0;
        end else begin
            r_vld[1] <= w_acc;
            for (int k = 2; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_stb <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_func[1] <= i_req.func;
        for (int k = 2; k <= LAST; k++) begin
            r_func[k] <= r_func[k-1];
        end
        r_ph_s <= w_phase;
        r_ph_c <= {w_phase[31:30] + 2'b01, w_phase[29:0]};
        r_side[tpa_pkg::WAVE_END+1] <= n_side;
        for (int k = tpa_pkg::WAVE_END + 2; k <= LAST; k++) begin
            r_side[k] <= r_side[k-1];
        end
        r_iv[tpa_pkg::INV_END+1] <= w_inv;
        for (int k = tpa_pkg::INV_END + 2; k <= LAST; k++) begin
            r_iv[k] <= r_iv[k-1];
        end
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_stb;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire

@@ verif/tb_trig_poly_approx_unit.sv @@
// tb_trig_poly_approx_unit: self-checking testbench for the trig polynomial unit.
// Bit-exact predictor, directed and random requests; depends on tpa_pkg and the RTL.
`timescale 1ns / 100ps

module tb_trig_poly_approx_unit;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    tpa_pkg::t_req i_req;
    logic          o_strobe;
    tpa_pkg::t_rsp o_rsp;

    tpa_pkg::t_rsp expected_rsps[$];
    int    err_count;
    int    req_count;
    int    rsp_count;

    trig_poly_approx_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_trig_poly_approx_unit: done, errors");
        $finish;
    end

    // ---------------- predictor ----------------
    localparam logic [63:0] CAP_Q30 = 64'd1 << 62;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    function automatic logic [63:0] coef(input logic [63:0] n);
        return ((n << 30) + 64'd5000000) / 64'd10000000;
    endfunction

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
        logic [127:0] full;
        logic [63:0]  p;
        full = {64'd0, a} * {64'd0, b};
        if (full[127:64] != 64'd0) begin
            sat = 1'b1;
            return CAP_Q30;
        end
        p = full[63:0] >> 30;
        if (p > CAP_Q30) begin
            sat = 1'b1;
            return CAP_Q30;
        end
        return p;
    endfunction

    function automatic logic [63:0] odd_quintic(input logic [63:0] ax, input logic [63:0] c1,
                                                input logic [63:0] c3, input logic [63:0] c5,
                                                inout logic sat);
        logic [63:0] x2, x4, pos, negt, g;
        x2   = mul_q30(ax, ax, sat);
        x4   = mul_q30(x2, x2, sat);
        pos  = c1 + mul_q30(c5, x4, sat);
        negt = mul_q30(c3, x2, sat);
        g    = (pos > negt) ? pos - negt : 64'd0;
        return mul_q30(ax, g, sat);
    endfunction

    function automatic logic [63:0] sine_mag(input logic [63:0] xs, input logic quarter,
                                             output logic neg);
        logic [63:0] t, m, r, pa, p2, a, b;
        t = xs * coef(64'd6366198);
        m = (t >> 16) & 64'hFFFF_FFFF;
        if (quarter) m = (m + ONE_Q30) & 64'hFFFF_FFFF;
        neg = m[31];
        r  = m & 64'h7FFF_FFFF;
        pa = (r >= ONE_Q30) ? r - ONE_Q30 : ONE_Q30 - r;
        p2 = (pa * pa) >> 30;
        a  = coef(64'd10017028) - p2;
        b  = coef(64'd44050123) - p2;
        return (((coef(64'd2265329) * a) >> 30) * b) >> 30;
    endfunction

    function automatic tpa_pkg::t_rsp round_sat(input logic neg, input logic [63:0] mag,
                                                input logic sat);
        logic [63:0]   r, lim;
        tpa_pkg::t_rsp res;
        lim = (64'd1 << 31) - (neg ? 64'd0 : 64'd1);
        r   = (mag + (64'd1 << 13)) >> 14;
        if (sat || r > lim) begin
            r   = lim;
            sat = 1'b1;
        end
        res.value    = neg ? -r[31:0] : r[31:0];
        res.overflow = sat;
        return res;
    endfunction

    function automatic tpa_pkg::t_rsp approx_result(input tpa_pkg::t_req rq);
        logic [63:0] xs, xmag, s, c, ax, m;
        logic        xneg, sn, cn, sat;
        logic signed [63:0] sv, av;
        xs   = {{32{rq.operand[31]}}, rq.operand};
        xneg = rq.operand[31];
        xmag = xneg ? -xs : xs;
        sat  = 1'b0;
        case (rq.func)
            tpa_pkg::FN_SIN, tpa_pkg::FN_COS: begin
                s = sine_mag(xs, rq.func == tpa_pkg::FN_COS, sn);
                return round_sat(sn, s, 1'b0);
            end
            tpa_pkg::FN_TAN: begin
                s = sine_mag(xs, 1'b0, sn);
                c = sine_mag(xs, 1'b1, cn);
                if (c == 64'd0) return round_sat(sn, CAP_Q30, 1'b1);
                return round_sat(sn != cn, (s << 30) / c, 1'b0);
            end
            tpa_pkg::FN_ASIN, tpa_pkg::FN_ACOS, tpa_pkg::FN_ATAN: begin
                ax = xmag << 14;
                if (rq.func == tpa_pkg::FN_ATAN) begin
                    m = odd_quintic(ax, coef(64'd9959826), coef(64'd2922813),
                                    coef(64'd830216), sat);
                    return round_sat(xneg, m, sat);
                end
                m = odd_quintic(ax, coef(64'd10469419), coef(64'd1610680),
                                coef(64'd5315243), sat);
                if (rq.func == tpa_pkg::FN_ASIN) return round_sat(xneg, m, sat);
                sv = xneg ? -$signed(m) : $signed(m);
                av = $signed(coef(64'd15707963)) - sv;
                if (av < 0) return round_sat(1'b1, -av, sat);
                return round_sat(1'b0, av, sat);
            end
            default: begin
                return '{value: '0, overflow: 1'b1};
            end
        endcase
    endfunction

    // ---------------- driver / checker ----------------
    task automatic send_request(input logic [2:0] fn, input logic [31:0] opnd,
                                input int gap);
        tpa_pkg::t_req rq;
        rq.func    = fn;
        rq.operand = opnd;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        expected_rsps.push_back(approx_result(rq));
        req_count++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        tpa_pkg::t_rsp want;
        if (i_rst_n && o_strobe) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", o_rsp.value, 32'd0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.value !== want.value)
                    report_mismatch("value", o_rsp.value, want.value);
                if (o_rsp.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_rsp.overflow), 32'(want.overflow));
            end
        end
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endfunction

    // ---------------- tests ----------------
    task automatic test_sine_cosine();
        logic [2:0] fn;
        for (int f = 0; f < 2; f++) begin
            fn = f[2:0];
            send_request(fn, 32'h0000_0000, 0);
            send_request(fn, 32'h0001_921F, 1);   // ~pi/2
            send_request(fn, 32'h0003_243F, 0);   // ~pi
            send_request(fn, 32'hFFFC_DBC1, 2);   // ~-pi
            send_request(fn, 32'h7FFF_FFFF, 0);
            send_request(fn, 32'h8000_0000, 0);
        end
    endtask

    task automatic test_tangent();
        send_request(tpa_pkg::FN_TAN, 32'h0001_921F, 0);   // near the pole
        send_request(tpa_pkg::FN_TAN, 32'hFFFE_6DE1, 3);
        send_request(tpa_pkg::FN_TAN, 32'h0000_C90F, 0);
        send_request(tpa_pkg::FN_TAN, 32'h7FFF_FFFF, 0);
    endtask

    task automatic test_inverse();
        logic [2:0] fn;
        for (int f = 3; f < 6; f++) begin
            fn = f[2:0];
            send_request(fn, 32'h0001_0000, 0);
            send_request(fn, 32'hFFFF_0000, 1);
            send_request(fn, 32'h7FFF_FFFF, 0);   // saturating intermediate
            send_request(fn, 32'h8000_0000, 0);
        end
    endtask

    task automatic test_unused_selector();
        send_request(3'd6, 32'h1234_5678, 0);
        send_request(3'd7, 32'hFFFF_FFFF, 4);
    endtask

    task automatic test_random(input int count);
        logic [31:0] opnd;
        logic [2:0]  fn;
        int          burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            case ($urandom_range(0, 3))
                0: opnd = $urandom();
                1: opnd = $urandom_range(0, 32'h0001_4000) - 32'h0000_A000; // ~[-0.6,0.6]+
                2: opnd = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000; // [-1.5,1.5]
                default: opnd = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            endcase
            if (burst > 0) begin
                burst--;
                send_request(fn, opnd, 0);
            end else begin
                if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
                send_request(fn, opnd, draw_gap());
            end
        end
    endtask

    initial begin
        err_count = 0;
        req_count = 0;
        rsp_count = 0;
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sine_cosine();
        test_tangent();
        test_inverse();
        test_unused_selector();
        test_random(1650);

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d requests over all six functions and unused selectors",
                 req_count);
        $display("Checked %0d results, directed edge cases plus random gaps and bursts",
                 rsp_count);
        if (err_count == 0) begin
            $display("tb_trig_poly_approx_unit: done, clean");
        end else begin
            $display("tb_trig_poly_approx_unit: done, errors");
        end
        $finish;
    end

endmodule
